>>> sv/ehc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types and constants for the emboss height colorizer.
// ----------------------------------------------------------------------------
package ehc_pkg;

    localparam int MaxValue  = 255;
    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_HI_RED   = 3'd1,
        REG_HI_GREEN = 3'd2,
        REG_HI_BLUE  = 3'd3,
        REG_LO_RED   = 3'd4,
        REG_LO_GREEN = 3'd5,
        REG_LO_BLUE  = 3'd6
    } reg_index_t;

    localparam logic [2:0] MODE_HI     = 3'd1;
    localparam logic [2:0] MODE_LO     = 3'd2;
    localparam logic [2:0] MODE_HI_REV = 3'd3;
    localparam logic [2:0] MODE_BLEND  = 3'd4;

    typedef enum logic [2:0] {
        OP_CONST = 3'd0,
        OP_PASS  = 3'd1,
        OP_BLEND = 3'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] g;
        logic [7:0] b;
    } cmd_t;

endpackage

>>> sv/ehc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_front
// Classifies each pixel by mask and mode and forms a command.
// ----------------------------------------------------------------------------
module ehc_front
    import ehc_pkg::*;
(
    input  logic [2:0] mode,
    input  logic [7:0] hi_red,
    input  logic [7:0] hi_green,
    input  logic [7:0] hi_blue,
    input  logic [7:0] lo_red,
    input  logic [7:0] lo_green,
    input  logic [7:0] lo_blue,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,
    output cmd_t       cmd
);

    localparam logic [7:0] MaxByte = 8'(MaxValue);

    always_comb
    begin
        cmd.op    = OP_CONST;
        cmd.red   = 8'd0;
        cmd.green = 8'd0;
        cmd.blue  = 8'd0;
        cmd.alpha = 8'd0;
        cmd.g     = in_green;
        cmd.b     = in_blue;
        if (in_red != 8'd0)
        begin
            case (mode)
                MODE_HI:
                begin
                    cmd.red = hi_red; cmd.green = hi_green; cmd.blue = hi_blue;
                    cmd.alpha = in_green;
                end
                MODE_LO:
                begin
                    cmd.red = lo_red; cmd.green = lo_green; cmd.blue = lo_blue;
                    cmd.alpha = in_blue;
                end
                MODE_HI_REV:
                begin
                    cmd.red = hi_red; cmd.green = hi_green; cmd.blue = hi_blue;
                    cmd.alpha = MaxByte - in_green;
                end
                MODE_BLEND:
                begin
                    if (in_green != 8'd0 && in_blue == 8'd0)
                    begin
                        cmd.red = hi_red; cmd.green = hi_green;
                        cmd.blue = hi_blue; cmd.alpha = in_green;
                    end
                    else if (in_green == 8'd0 && in_blue != 8'd0)
                    begin
                        cmd.red = lo_red; cmd.green = lo_green;
                        cmd.blue = lo_blue; cmd.alpha = in_blue;
                    end
                    else if (in_green != 8'd0)
                    begin
                        cmd.op = OP_BLEND;
                        cmd.red = hi_red; cmd.green = hi_green; cmd.blue = hi_blue;
                        cmd.alpha = 8'd0;
                    end
                end
                default:
                begin
                    cmd.red = in_red; cmd.green = in_green; cmd.blue = in_blue;
                    cmd.alpha = in_alpha;
                end
            endcase
        end
    end

endmodule

>>> sv/ehc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_queue
// Short FIFO of commands between classifier and blend pipeline.
// ----------------------------------------------------------------------------
module ehc_queue
    import ehc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PtrW = $clog2(QueueDepth);

    cmd_t            mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW:0]   count_reg;

    assign full     = (count_reg == (PtrW+1)'(QueueDepth));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

endmodule

>>> sv/ehc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_back
// Pipelined Hi-Lo blend: alpha, then per-channel reciprocal-free division by
// restoring steps spread over stages, with an output register.
// ----------------------------------------------------------------------------
module ehc_back
    import ehc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] lo_red,
    input  logic [7:0] lo_green,
    input  logic [7:0] lo_blue,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    output logic       valid,
    input  logic       ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);

    // Pipeline: S0 products, S1 alpha, S2..S5 quotient bits (3, 2, 2, 2 per stage),
    // then output. Stage count NStg = 7 holding registers.
    localparam int NStg = 7;

    typedef struct packed {
        op_t         op;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] gb;
        logic [16:0] nr;
        logic [16:0] ng;
        logic [16:0] nb;
        logic [8:0]  den;
        logic [16:0] rr;
        logic [16:0] rg;
        logic [16:0] rb;
        logic [8:0]  qr;
        logic [8:0]  qg;
        logic [8:0]  qb;
    } stg_t;

    stg_t  stg_reg [NStg];
    logic  vld_reg [NStg];
    logic  adv;
    stg_t  s0, s1;
    stg_t  sd [4];

    assign adv     = !vld_reg[NStg-1] || ready;
    assign cmd_pop = cmd_valid && adv;

    // Stage 0: products.
    always_comb
    begin
        s0       = '0;
        s0.op    = cmd.op;
        s0.red   = cmd.red;
        s0.green = cmd.green;
        s0.blue  = cmd.blue;
        s0.alpha = cmd.alpha;
        s0.gb    = 16'(cmd.g) * 16'(cmd.b);
        s0.nr    = 17'(16'(cmd.red) * 16'(cmd.g)) + 17'(16'(lo_red) * 16'(cmd.b));
        s0.ng    = 17'(16'(cmd.green) * 16'(cmd.g)) + 17'(16'(lo_green) * 16'(cmd.b));
        s0.nb    = 17'(16'(cmd.blue) * 16'(cmd.g)) + 17'(16'(lo_blue) * 16'(cmd.b));
        s0.den   = 9'(cmd.g) + 9'(cmd.b);
    end

    // Stage 1: alpha = g + b - floor(gb/255), via (x + 1 + (x >> 8)) >> 8.
    logic [16:0] t255;
    logic [8:0]  al;
    always_comb
    begin
        s1   = stg_reg[0];
        t255 = (17'(stg_reg[0].gb) + 17'd1 + 17'(stg_reg[0].gb >> 8)) >> 8;
        al   = stg_reg[0].den - t255[8:0];
        if (al > 9'(MaxValue))
        begin
            al = 9'(MaxValue);
        end
        s1.den = al;
        if (stg_reg[0].op == OP_BLEND)
        begin
            s1.alpha = al[7:0];
        end
        s1.rr = '0; s1.rg = '0; s1.rb = '0;
        s1.qr = '0; s1.qg = '0; s1.qb = '0;
    end

    // Quotient < 512 (9 bits); bits 8..0 produced 3,2,2,2 over four stages.
    function automatic void qstep(input logic [16:0] n, input logic [8:0] d,
                                  input int bitn,
                                  inout logic [16:0] r, inout logic [8:0] q);
        logic [17:0] trial;
        trial = {r, n[bitn]};
        if (trial >= 18'(d))
        begin
            r = 17'(trial - 18'(d));
            q[bitn - 8 + 8] = 1'b1;
        end
        else
        begin
            r = trial[16:0];
        end
    endfunction

    // Numerator < 2^17, quotient must be < 512 so first 8 bits give zero
    // remainder seed: preload remainder with n >> 9.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sd[k] = stg_reg[k+1];
        end
        begin
            sd[0].rr = 17'(stg_reg[1].nr >> 9);
            sd[0].rg = 17'(stg_reg[1].ng >> 9);
            sd[0].rb = 17'(stg_reg[1].nb >> 9);
            for (int i = 8; i >= 6; i--)
            begin
                qstep(stg_reg[1].nr, stg_reg[1].den, i, sd[0].rr, sd[0].qr);
                qstep(stg_reg[1].ng, stg_reg[1].den, i, sd[0].rg, sd[0].qg);
                qstep(stg_reg[1].nb, stg_reg[1].den, i, sd[0].rb, sd[0].qb);
            end
        end
        for (int k = 1; k < 4; k++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                qstep(stg_reg[k+1].nr, stg_reg[k+1].den, 5 - 2*(k-1) - j,
                      sd[k].rr, sd[k].qr);
                qstep(stg_reg[k+1].ng, stg_reg[k+1].den, 5 - 2*(k-1) - j,
                      sd[k].rg, sd[k].qg);
                qstep(stg_reg[k+1].nb, stg_reg[k+1].den, 5 - 2*(k-1) - j,
                      sd[k].rb, sd[k].qb);
            end
        end
    end

    function automatic logic [7:0] clip(input logic [8:0] q);
        logic [8:0] m;
        m = (q > 9'(MaxValue)) ? 9'(MaxValue) : q;
        return (m > 9'd255) ? 8'd255 : m[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg[0] <= s0;
            stg_reg[1] <= s1;
            for (int k = 0; k < 4; k++)
            begin
                stg_reg[k+2] <= sd[k];
            end
            stg_reg[NStg-1] <= stg_reg[NStg-2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NStg; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= cmd_valid;
            for (int k = 1; k < NStg; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    logic blend_out;
    logic zero_den;
    assign blend_out = (stg_reg[NStg-1].op == OP_BLEND);
    assign zero_den  = (stg_reg[NStg-1].den == 9'd0);
    assign valid     = vld_reg[NStg-1];
    assign out_red   = !blend_out ? stg_reg[NStg-1].red :
                       (zero_den ? 8'd0 : clip(stg_reg[NStg-1].qr));
    assign out_green = !blend_out ? stg_reg[NStg-1].green :
                       (zero_den ? 8'd0 : clip(stg_reg[NStg-1].qg));
    assign out_blue  = !blend_out ? stg_reg[NStg-1].blue :
                       (zero_den ? 8'd0 : clip(stg_reg[NStg-1].qb));
    assign out_alpha = stg_reg[NStg-1].alpha;

endmodule

>>> sv/emboss_height_colorise.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emboss_height_colorise
// Colors an emboss pixel by mode: highlight, shadow, reversed, Hi-Lo blend or pass-through.
// ----------------------------------------------------------------------------
// One pixel per clock sustained. The pixel is written into the command queue
// when accepted, then passes through registers for product, alpha, four
// division stages and the output register. A stalled output holds the whole
// pipeline; input stalls once the two-entry queue fills.
module emboss_height_colorise
    import ehc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);

    logic [2:0] mode_reg;
    logic [7:0] hi_red_reg, hi_green_reg, hi_blue_reg;
    logic [7:0] lo_red_reg, lo_green_reg, lo_blue_reg;
    cmd_t       front_cmd, queue_cmd;
    logic       q_full, q_empty, q_pop, push;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign push      = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            hi_red_reg <= '0; hi_green_reg <= '0; hi_blue_reg <= '0;
            lo_red_reg <= '0; lo_green_reg <= '0; lo_blue_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_MODE:     mode_reg     <= cfg_data[2:0];
                REG_HI_RED:   hi_red_reg   <= cfg_data;
                REG_HI_GREEN: hi_green_reg <= cfg_data;
                REG_HI_BLUE:  hi_blue_reg  <= cfg_data;
                REG_LO_RED:   lo_red_reg   <= cfg_data;
                REG_LO_GREEN: lo_green_reg <= cfg_data;
                REG_LO_BLUE:  lo_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    ehc_front u_front (
        .mode(mode_reg), .hi_red(hi_red_reg), .hi_green(hi_green_reg),
        .hi_blue(hi_blue_reg), .lo_red(lo_red_reg), .lo_green(lo_green_reg),
        .lo_blue(lo_blue_reg), .in_red(in_red), .in_green(in_green),
        .in_blue(in_blue), .in_alpha(in_alpha), .cmd(front_cmd)
    );

    ehc_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(front_cmd),
        .full(q_full), .pop(q_pop), .pop_data(queue_cmd), .empty(q_empty)
    );

    ehc_back u_back (
        .clk(clk), .rst_n(rst_n), .lo_red(lo_red_reg), .lo_green(lo_green_reg),
        .lo_blue(lo_blue_reg), .cmd_valid(!q_empty), .cmd(queue_cmd),
        .cmd_pop(q_pop), .valid(out_valid), .ready(out_ready),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha)
    );

endmodule
